FILE: rtl/rts_pkg.sv
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types, codes and character constants for the RTF token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package rts_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int TABLE_IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CODE_WIDTH    = 16;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [7:0] LOW7_MASK = 8'h7F;
  localparam logic [7:0] CH_A      = 8'h61;  // 'a'
  localparam logic [7:0] CH_Z      = 8'h7A;  // 'z'
  localparam logic [7:0] CH_U      = 8'h75;  // 'u'
  localparam logic [7:0] CH_0      = 8'h30;  // '0'
  localparam logic [7:0] CH_9      = 8'h39;  // '9'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
  localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '

  localparam logic [35:0] LIMIT_POS = 36'h0_7FFF_FFFF;
  localparam logic [35:0] LIMIT_NEG = 36'h0_8000_0000;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_END   = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_OPEN   = 3'd0,
    K_CLOSE  = 3'd1,
    K_CHAR   = 3'd2,
    K_LETTER = 3'd3,
    K_CEND   = 3'd4,
    K_ERROR  = 3'd5,
    K_EOS    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_ESC   = 3'd1,
    M_UPEND = 3'd2,
    M_WORD  = 3'd3,
    M_WNUM  = 3'd4,
    M_UNUM  = 3'd5,
    M_SKIP  = 3'd6,
    M_DEAD  = 3'd7
  } mode_e;

  typedef enum logic [0:0] {
    REG_TABLE_ENABLE = 1'b0,
    REG_UNICODE_SKIP = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [6:0]  entry_index;
    logic [15:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic               has_argument;
    logic signed [31:0] argument;
    logic               last;
  } out_word_t;

  // Token as produced by the scanner; value may still need the table lookup.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        has_arg;
    logic [31:0] arg;
    logic        use_table;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } tok_pair_t;

endpackage

`default_nettype wire

FILE: rtl/rts_scan_core.sv
// ----------------------------------------------------------------------------
// rts_scan_core
// Scan state machine: takes one word per cycle while accept is high, emits up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module rts_scan_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  rts_pkg::in_word_t  in_word,
  input  logic               table_enable,
  input  logic [3:0]         skip_count,
  output rts_pkg::tok_pair_t toks
);
  import rts_pkg::*;

  mode_e       mode_r,   mode_nxt;
  logic [31:0] acc_r,    acc_nxt;
  logic        neg_r,    neg_nxt;
  logic        digit_r,  digit_nxt;
  logic [3:0]  skip_r,   skip_nxt;
  logic [7:0]  held_r,   held_nxt;

  function automatic tok_t mk_tok(logic [2:0] k, logic [31:0] v, logic h, logic [31:0] a);
    tok_t t;
    t.kind      = k;
    t.value     = v;
    t.has_arg   = h;
    t.arg       = a;
    t.use_table = 1'b0;
    return t;
  endfunction

  // Plain byte in idle: open, close or character (backslash handled by caller).
  function automatic tok_t plain_tok(logic [7:0] b, logic en);
    tok_t t;
    if (b == CH_LBRACE) begin
      t = mk_tok(K_OPEN, 32'd0, 1'b0, '1);
    end else if (b == CH_RBRACE) begin
      t = mk_tok(K_CLOSE, 32'd0, 1'b0, '1);
    end else begin
      t = mk_tok(K_CHAR, {24'd0, b}, 1'b0, '1);
      t.use_table = en && ((b & ~LOW7_MASK) != 8'd0);
    end
    return t;
  endfunction

  logic [7:0]  b;
  logic        is_lower, is_dec, is_nstart, is_bslash, is_space;
  logic [35:0] num_next;
  logic [35:0] limit;
  logic [31:0] num_val;
  logic [3:0]  skip_dec;

  assign b         = in_word.data_byte;
  assign is_lower  = (b >= CH_A) && (b <= CH_Z);
  assign is_dec    = (b >= CH_0) && (b <= CH_9);
  assign is_nstart = is_dec || (b == CH_MINUS);
  assign is_bslash = (b == CH_BSLASH);
  assign is_space  = (b == CH_SPACE);
  // acc * 10 + digit, as shift-add
  assign num_next  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                   + {32'd0, b[3:0] - CH_0[3:0]};
  assign limit     = neg_r ? LIMIT_NEG : LIMIT_POS;
  assign num_val   = neg_r ? (32'd0 - acc_r) : acc_r;
  assign skip_dec  = skip_count - 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      digit_r <= 1'b0;
      skip_r  <= '0;
      held_r  <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      digit_r <= digit_nxt;
      skip_r  <= skip_nxt;
      held_r  <= held_nxt;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    digit_nxt = digit_r;
    skip_nxt  = skip_r;
    held_nxt  = held_r;
    toks.cnt  = 2'd0;
    toks.t0   = mk_tok(K_EOS, 32'd0, 1'b0, '1);
    toks.t1   = mk_tok(K_EOS, 32'd0, 1'b0, '1);

    if (in_word.op == OP_DATA) begin
      unique case (mode_r) inside
        M_IDLE: begin
          if (is_bslash) begin
            mode_nxt = M_ESC;
          end else begin
            toks.t0  = plain_tok(b, table_enable);
            toks.cnt = 2'd1;
          end
        end
        M_ESC: begin
          if (b == CH_LBRACE || b == CH_RBRACE || is_bslash) begin
            toks.t0  = mk_tok(K_CHAR, {24'd0, b}, 1'b0, '1);
            toks.cnt = 2'd1;
            mode_nxt = M_IDLE;
          end else if (is_lower) begin
            held_nxt = b;
            mode_nxt = (b == CH_U) ? M_UPEND : M_WORD;
          end else begin
            toks.t0  = mk_tok(K_ERROR, {24'd0, b}, 1'b0, '1);
            toks.cnt = 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_UPEND, M_WORD: begin
          if (is_nstart) begin
            neg_nxt   = (b == CH_MINUS);
            digit_nxt = is_dec;
            acc_nxt   = is_dec ? {28'd0, b[3:0] - CH_0[3:0]} : 32'd0;
            mode_nxt  = (mode_r == M_UPEND) ? M_UNUM : M_WNUM;
          end else if (is_lower) begin
            toks.t0  = mk_tok(K_LETTER, {24'd0, held_r}, 1'b0, '1);
            toks.cnt = 2'd1;
            held_nxt = b;
            mode_nxt = M_WORD;
          end else begin
            toks.t0  = mk_tok(K_CEND, {24'd0, held_r}, 1'b0, '1);
            toks.cnt = 2'd1;
            mode_nxt = M_IDLE;
            if (!is_space) begin
              if (is_bslash) begin
                mode_nxt = M_ESC;
              end else begin
                toks.t1  = plain_tok(b, table_enable);
                toks.cnt = 2'd2;
              end
            end
          end
        end
        M_WNUM, M_UNUM: begin
          if (is_dec) begin
            if (num_next > limit) begin
              toks.t0  = mk_tok(K_ERROR, {24'd0, b}, 1'b0, '1);
              toks.cnt = 2'd1;
              mode_nxt = M_DEAD;
            end else begin
              acc_nxt   = num_next[31:0];
              digit_nxt = 1'b1;
            end
          end else if (!digit_r) begin
            toks.t0  = mk_tok(K_ERROR, {24'd0, b}, 1'b0, '1);
            toks.cnt = 2'd1;
            mode_nxt = M_DEAD;
          end else if (mode_r == M_WNUM) begin
            toks.t0  = mk_tok(K_CEND, {24'd0, held_r}, 1'b1, num_val);
            toks.cnt = 2'd1;
            mode_nxt = M_IDLE;
            if (!is_space) begin
              if (is_bslash) begin
                mode_nxt = M_ESC;
              end else begin
                toks.t1  = plain_tok(b, table_enable);
                toks.cnt = 2'd2;
              end
            end
          end else begin
            toks.t0  = mk_tok(K_CHAR, num_val, 1'b0, '1);
            toks.cnt = 2'd1;
            mode_nxt = M_IDLE;
            if (skip_count != 4'd0) begin
              // terminating byte is the first one skipped
              skip_nxt = skip_dec;
              if (skip_dec != 4'd0) mode_nxt = M_SKIP;
            end else if (is_bslash) begin
              mode_nxt = M_ESC;
            end else begin
              toks.t1  = plain_tok(b, table_enable);
              toks.cnt = 2'd2;
            end
          end
        end
        M_SKIP: begin
          skip_nxt = (skip_r != 4'd0) ? skip_r - 4'd1 : skip_r;
          if (skip_nxt == 4'd0) mode_nxt = M_IDLE;
        end
        M_DEAD: begin
        end
        default: begin
        end
      endcase
    end else if (in_word.op == OP_END) begin
      toks.t1  = mk_tok(K_EOS, 32'd0, 1'b0, '1);
      toks.cnt = 2'd2;
      unique case (mode_r) inside
        M_ESC: toks.t0 = mk_tok(K_ERROR, 32'd0, 1'b0, '1);
        M_UPEND, M_WORD: toks.t0 = mk_tok(K_CEND, {24'd0, held_r}, 1'b0, '1);
        M_WNUM: toks.t0 = digit_r ? mk_tok(K_CEND, {24'd0, held_r}, 1'b1, num_val)
                                  : mk_tok(K_ERROR, 32'd0, 1'b0, '1);
        M_UNUM: toks.t0 = digit_r ? mk_tok(K_CHAR, num_val, 1'b0, '1)
                                  : mk_tok(K_ERROR, 32'd0, 1'b0, '1);
        default: begin
          toks.t0  = mk_tok(K_EOS, 32'd0, 1'b0, '1);
          toks.cnt = 2'd1;
        end
      endcase
      mode_nxt  = M_IDLE;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      digit_nxt = 1'b0;
      skip_nxt  = '0;
      held_nxt  = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rts_result_fifo.sv
// ----------------------------------------------------------------------------
// rts_result_fifo
// Result queue: up to two words pushed per cycle, one popped per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rts_result_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   push_cnt,
  input  rts_pkg::out_word_t           push0,
  input  rts_pkg::out_word_t           push1,
  input  logic                         pop,
  output rts_pkg::out_word_t           head,
  output logic [rts_pkg::FIFO_CNT_W-1:0] count
);
  import rts_pkg::*;

  out_word_t             slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r,  count_nxt;
  logic [FIFO_PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + FIFO_PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
  assign head       = slots[rd_ptr_r];
  assign count      = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) slots[wr_ptr_r]  <= push0;
    if (push_cnt == 2'd2) slots[wr_ptr_p1] <= push1;
  end

endmodule

`default_nettype wire

FILE: rtl/rtf_token_scanner.sv
// ----------------------------------------------------------------------------
// rtf_token_scanner
// RTF control-word tokenizer: one byte word in, group/char/control tokens out.
// ----------------------------------------------------------------------------
// One input word is taken per clock while in_ready is high; a word gives zero,
// one or two result words, and results leave at one per clock while out_ready
// is high, so the input rate is one word per cycle as long as most words give
// at most one result. A word's results reach out_valid by way of the stage B
// registers and the queue: the accepting cycle runs the scan state machine and
// issues the code table read, then stage B merges the registered table data into the token and queues it.
// The result queue holds eight words; in_ready drops when it cannot absorb
// two more results on top of what is already in flight. The code table is a
// 128-entry memory written by op 2 words and is not cleared after reset;
// configuration sits on a small APB-style port (table_enable at 0x0,
// unicode_skip_count at 0x4) and must only be written while the block is idle.
`default_nettype none

module rtf_token_scanner #(
  parameter int CODE_WIDTH = rts_pkg::CODE_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  rts_pkg::in_word_t  in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output rts_pkg::out_word_t out_data,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rts_pkg::*;

  // ---------------- configuration registers ----------------
  logic       table_en_r;
  logic [3:0] uskip_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_en_r <= 1'b0;
      uskip_r    <= 4'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_UNICODE_SKIP) uskip_r <= pwdata[3:0];
      else                              table_en_r <= pwdata[0];
    end
  end

  // register index sits in paddr[2]; byte offset bits are ignored
  assign prdata = (paddr[2] == REG_UNICODE_SKIP) ? {28'd0, uskip_r} : {31'd0, table_en_r};

  // ---------------- handshake ----------------
  logic                  accept;
  logic [FIFO_CNT_W-1:0] q_count;
  logic [1:0]            b_cnt_r;
  logic [FIFO_CNT_W:0]   backlog;

  // room for what is queued, what stage B carries, and two more
  assign backlog  = {1'b0, q_count} + (FIFO_CNT_W + 1)'(b_cnt_r);
  assign in_ready = (backlog <= (FIFO_CNT_W + 1)'(FIFO_DEPTH - 2));
  assign accept   = in_valid && in_ready;

  // ---------------- scanner (stage A) ----------------
  tok_pair_t toks;

  rts_scan_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_word      (in_data),
    .table_enable (table_en_r),
    .skip_count   (uskip_r),
    .toks         (toks)
  );

  // ---------------- code table ----------------
  logic [CODE_WIDTH-1:0]  table_mem [TABLE_ENTRIES];
  logic [CODE_WIDTH-1:0]  tbl_rdata_r;
  logic [CODE_WIDTH+15:0] wr_ext;
  logic [TABLE_IDX_W-1:0] rd_idx;
  logic [TABLE_IDX_W-1:0] wr_idx;

  assign wr_ext = {{CODE_WIDTH{1'b0}}, in_data.entry_value};
  assign rd_idx = in_data.data_byte[TABLE_IDX_W-1:0];
  assign wr_idx = in_data.entry_index[TABLE_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (accept && in_data.op == OP_WRITE) table_mem[wr_idx] <= wr_ext[CODE_WIDTH-1:0];
    if (accept && in_data.op == OP_DATA)  tbl_rdata_r <= table_mem[rd_idx];
  end

  // ---------------- stage B: token registers ----------------
  tok_pair_t b_toks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_cnt_r <= 2'd0;
    else        b_cnt_r <= accept ? toks.cnt : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (accept) b_toks_r <= toks;
  end

  function automatic out_word_t finish(tok_t t, logic [CODE_WIDTH-1:0] code, logic lst);
    out_word_t w;
    w.kind         = t.kind;
    w.value        = t.use_table ? {{(32 - CODE_WIDTH){1'b0}}, code} : t.value;
    w.has_argument = t.has_arg;
    w.argument     = t.arg;
    w.last         = lst;
    return w;
  endfunction

  out_word_t res0, res1;

  assign res0 = finish(b_toks_r.t0, tbl_rdata_r, b_cnt_r == 2'd1);
  assign res1 = finish(b_toks_r.t1, tbl_rdata_r, 1'b1);

  // ---------------- result queue ----------------
  logic q_pop;

  assign out_valid = (q_count != '0);
  assign q_pop     = out_valid && out_ready;

  rts_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (b_cnt_r),
    .push0    (res0),
    .push1    (res1),
    .pop      (q_pop),
    .head     (out_data),
    .count    (q_count)
  );

endmodule

`default_nettype wire

FILE: sim/tb_rtf_token_scanner.sv
// ----------------------------------------------------------------------------
// tb_rtf_token_scanner
// Self-checking bench for the RTF token scanner: a directed table (some rows
// hand-typed), then random RTF-like fragments under several register settings,
// scored by an in-bench token predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rtf_token_scanner;
  import rts_pkg::*;

  localparam int          CYCLE_LIMIT = 400_000;
  localparam int          DRAIN_WAIT  = 12;     // margin past the result pipeline
  localparam int          PHASE_WORDS = 250;
  localparam int          N_PHASES    = 6;
  localparam int          DIR_ROWS    = 28;
  localparam logic [31:0] NO_ARG      = 32'hFFFF_FFFF;

  typedef struct {
    in_word_t  w;
    bit        typed;   // res holds a hand-written token for this row
    out_word_t res;
  } dir_row_t;

  // clock, reset and block ports
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state, mirrors the scanner
  mode_e       scan_st;
  logic [31:0] num_acc;
  logic        num_neg;
  logic        num_digit;
  logic [3:0]  skip_left;
  logic [7:0]  held_ch;
  logic [15:0] code_mem [TABLE_ENTRIES];
  bit          entry_set [TABLE_ENTRIES];
  logic        tbl_en;
  logic [3:0]  uskip;

  // tokens from the word being predicted
  out_word_t step_res [2];
  int        step_n;

  out_word_t tokens_due [$];
  out_word_t want;

  bit calm = 1'b0;    // no idling on either side while set
  int words_fed, tokens_checked, fails, cycle_cnt;

  dir_row_t dir_tab [DIR_ROWS];

  rtf_token_scanner i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Token predictor
  // --------------------------------------------------------------------------
  function automatic bit is_lower(logic [7:0] b);
    return b >= CH_A && b <= CH_Z;
  endfunction

  function automatic bit is_decimal(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  // at most two tokens per word; extras are dropped like in the block
  function automatic void emit_token(kind_e k, logic [31:0] v, logic h, logic [31:0] a);
    if (step_n >= 2) return;
    step_res[step_n].kind         = k;
    step_res[step_n].value        = v;
    step_res[step_n].has_argument = h;
    step_res[step_n].argument     = a;
    step_res[step_n].last         = 1'b0;
    step_n++;
  endfunction

  function automatic logic [31:0] char_code(logic [7:0] b);
    if (b[7] && tbl_en) return {16'd0, code_mem[b[6:0]]};
    return {24'd0, b};
  endfunction

  function automatic void clear_scan();
    scan_st   = M_IDLE;
    num_acc   = '0;
    num_neg   = 1'b0;
    num_digit = 1'b0;
    skip_left = '0;
    held_ch   = '0;
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    scan_st = M_IDLE;
    if (b == CH_LBRACE) emit_token(K_OPEN, '0, 1'b0, NO_ARG);
    else if (b == CH_RBRACE) emit_token(K_CLOSE, '0, 1'b0, NO_ARG);
    else if (b == CH_BSLASH) scan_st = M_ESC;
    else emit_token(K_CHAR, char_code(b), 1'b0, NO_ARG);
  endfunction

  function automatic void begin_number(logic [7:0] b, mode_e m);
    num_neg   = (b == CH_MINUS);
    num_digit = (b != CH_MINUS);
    num_acc   = (b == CH_MINUS) ? 32'd0 : 32'(b - CH_0);
    scan_st   = m;
  endfunction

  // true when b is a digit; overflow kills the scanner
  function automatic bit take_digit(logic [7:0] b);
    logic [63:0] nxt, lim;
    if (!is_decimal(b)) return 1'b0;
    nxt = 64'(num_acc) * 64'd10 + 64'(b - CH_0);
    lim = num_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (nxt > lim) begin
      emit_token(K_ERROR, 32'(b), 1'b0, NO_ARG);
      scan_st = M_DEAD;
    end else begin
      num_acc   = nxt[31:0];
      num_digit = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void byte_step(logic [7:0] b);
    case (scan_st)
      M_IDLE: plain_byte(b);
      M_ESC: begin
        if (b == CH_LBRACE || b == CH_RBRACE || b == CH_BSLASH) begin
          emit_token(K_CHAR, 32'(b), 1'b0, NO_ARG);
          scan_st = M_IDLE;
        end else if (is_lower(b)) begin
          held_ch = b;
          scan_st = (b == CH_U) ? M_UPEND : M_WORD;
        end else begin
          emit_token(K_ERROR, 32'(b), 1'b0, NO_ARG);
          scan_st = M_IDLE;
        end
      end
      M_UPEND, M_WORD: begin
        if (scan_st == M_UPEND && (is_decimal(b) || b == CH_MINUS)) begin
          begin_number(b, M_UNUM);
        end else if (is_lower(b)) begin
          emit_token(K_LETTER, 32'(held_ch), 1'b0, NO_ARG);
          held_ch = b;
          scan_st = M_WORD;
        end else if (is_decimal(b) || b == CH_MINUS) begin
          begin_number(b, M_WNUM);
        end else begin
          emit_token(K_CEND, 32'(held_ch), 1'b0, NO_ARG);
          scan_st = M_IDLE;
          if (b != CH_SPACE) plain_byte(b);   // one space is swallowed
        end
      end
      M_WNUM, M_UNUM: begin
        if (!take_digit(b)) begin
          if (!num_digit) begin
            // lone minus
            emit_token(K_ERROR, 32'(b), 1'b0, NO_ARG);
            scan_st = M_DEAD;
          end else if (scan_st == M_WNUM) begin
            emit_token(K_CEND, 32'(held_ch), 1'b1, num_neg ? -num_acc : num_acc);
            scan_st = M_IDLE;
            if (b != CH_SPACE) plain_byte(b);
          end else begin
            // unicode escape: the ending byte is the first one skipped
            emit_token(K_CHAR, num_neg ? -num_acc : num_acc, 1'b0, NO_ARG);
            scan_st = M_IDLE;
            if (uskip != 0) begin
              skip_left = uskip - 4'd1;
              if (skip_left != 0) scan_st = M_SKIP;
            end else begin
              plain_byte(b);
            end
          end
        end
      end
      M_SKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) scan_st = M_IDLE;
      end
      default: ;   // dead: bytes ignored until end of stream
    endcase
  endfunction

  function automatic void flush_stream();
    case (scan_st)
      M_ESC: emit_token(K_ERROR, '0, 1'b0, NO_ARG);
      M_UPEND, M_WORD: emit_token(K_CEND, 32'(held_ch), 1'b0, NO_ARG);
      M_WNUM: begin
        if (num_digit) emit_token(K_CEND, 32'(held_ch), 1'b1, num_neg ? -num_acc : num_acc);
        else emit_token(K_ERROR, '0, 1'b0, NO_ARG);
      end
      M_UNUM: begin
        if (num_digit) emit_token(K_CHAR, num_neg ? -num_acc : num_acc, 1'b0, NO_ARG);
        else emit_token(K_ERROR, '0, 1'b0, NO_ARG);
      end
      default: ;
    endcase
    emit_token(K_EOS, '0, 1'b0, NO_ARG);
    clear_scan();
  endfunction

  // works out the tokens caused by one accepted word
  function automatic void scan_word(in_word_t w);
    step_n = 0;
    case (op_e'(w.op))
      OP_DATA: byte_step(w.data_byte);
      OP_END:  flush_stream();
      OP_WRITE: begin
        code_mem[w.entry_index]  = w.entry_value;
        entry_set[w.entry_index] = 1'b1;
      end
      default: ;
    endcase
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // appends one token to the list of tokens still due
  function automatic void queue_token(out_word_t t);
    tokens_due = {tokens_due, t};
  endfunction

  // Entered and left just after a falling edge; valid stays high between
  // back-to-back words so it is never lowered and raised in one step.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    int i;
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (w.op != OP_NONE && !(w.op == OP_DATA && scan_st == M_DEAD)) words_fed++;
    scan_word(w);
    if (typed) queue_token(typed_res);
    else for (i = 0; i < step_n; i++) queue_token(step_res[i]);
    @(negedge clk);
  endtask

  task automatic send_op(op_e op);
    in_word_t w;
    w.op          = op;
    w.data_byte   = 8'($urandom_range(255));
    w.entry_index = 7'($urandom_range(127));
    w.entry_value = 16'($urandom_range(65535));
    send_word(w, 1'b0, '0);
  endtask

  // high bytes get their table entry loaded first so no unwritten entry is read
  task automatic send_byte(logic [7:0] b);
    in_word_t w;
    if (b[7] && !entry_set[b[6:0]]) begin
      w.op          = OP_WRITE;
      w.data_byte   = 8'($urandom_range(255));
      w.entry_index = b[6:0];
      w.entry_value = 16'($urandom_range(65535));
      send_word(w, 1'b0, '0);
    end
    w.op          = OP_DATA;
    w.data_byte   = b;
    w.entry_index = 7'($urandom_range(127));
    w.entry_value = 16'($urandom_range(65535));
    send_word(w, 1'b0, '0);
  endtask

  // waits for the scanner to go quiet, input held low
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // write then read back one register
  task automatic cfg_write(reg_idx_e r, logic [31:0] v);
    logic [31:0] m;
    m       = (r == REG_TABLE_ENABLE) ? 32'h1 : 32'hF;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * r);
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (r == REG_TABLE_ENABLE) tbl_en = v[0];
    else uskip = v[3:0];
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & m) !== (v & m)) begin
      $display("%0t: reg %0d readback expected %h actual %h", $time, r, v & m, prdata & m);
      fails++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random RTF-like stimulus
  // --------------------------------------------------------------------------
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(3) == 0) return 8'h80 + 8'($urandom_range(127));
    do b = 8'($urandom_range(8'h7E, 8'h20));
    while (b == CH_BSLASH || b == CH_LBRACE || b == CH_RBRACE);
    return b;
  endfunction

  function automatic longint pick_number();
    case ($urandom_range(7))
      0, 1, 2: return longint'($urandom_range(99));
      3:       return longint'($urandom_range(65535));
      4:       return longint'(int'($urandom()));
      5: begin
        case ($urandom_range(3))
          0:       return 64'sd2147483647;
          1:       return -64'sd2147483648;
          2:       return -64'sd2147483647;
          default: return 64'sd0;
        endcase
      end
      6: begin
        // just past either limit, or far out
        case ($urandom_range(2))
          0:       return 64'sd2147483648 + longint'($urandom_range(9));
          1:       return -64'sd2147483649 - longint'($urandom_range(9));
          default: return 64'sd99999999999;
        endcase
      end
      default: return -longint'($urandom_range(999, 1));
    endcase
  endfunction

  task automatic send_number(longint n);
    string s;
    int    i;
    s = $sformatf("%0d", n);
    if (n >= 0 && $urandom_range(9) == 0) s = {"00", s};
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_letters(int cnt);
    repeat (cnt) send_byte(CH_A + 8'($urandom_range(25)));
  endtask

  task automatic feed_fragment();
    logic [7:0] b;
    case ($urandom_range(19))
      0, 1, 2: repeat ($urandom_range(6, 1)) send_byte(text_byte());
      3: send_byte(CH_LBRACE);
      4: send_byte(CH_RBRACE);
      5, 6, 7, 8: begin
        // control word, maybe with an argument, then maybe a terminator
        send_byte(CH_BSLASH);
        send_letters($urandom_range(5, 1));
        if ($urandom_range(1)) send_number(pick_number());
        case ($urandom_range(3))
          0: send_byte(CH_SPACE);
          1: ;
          2: send_byte(text_byte());
          default: send_byte(8'($urandom_range(255)));
        endcase
      end
      9, 10: begin
        // unicode escape and its fallback bytes
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        if ($urandom_range(3) == 0) send_number(pick_number());
        else send_number(longint'($urandom_range(65535)));
        repeat ($urandom_range(uskip + 1)) send_byte(8'($urandom_range(255)));
      end
      11: begin
        send_byte(CH_BSLASH);
        case ($urandom_range(2))
          0:       send_byte(CH_LBRACE);
          1:       send_byte(CH_RBRACE);
          default: send_byte(CH_BSLASH);
        endcase
      end
      12: begin
        // bad escape
        do b = 8'($urandom_range(255));
        while (is_lower(b) || b == CH_LBRACE || b == CH_RBRACE || b == CH_BSLASH);
        send_byte(CH_BSLASH);
        send_byte(b);
      end
      13: begin
        // lone minus after a word or after \u
        send_byte(CH_BSLASH);
        if ($urandom_range(1)) send_byte(CH_U);
        else send_letters($urandom_range(3, 1));
        send_byte(CH_MINUS);
        do b = 8'($urandom_range(255)); while (is_decimal(b));
        send_byte(b);
      end
      14: send_op(OP_END);
      15: send_op(OP_WRITE);
      16: send_op(OP_NONE);
      default: send_byte(8'($urandom_range(255)));
    endcase
  endtask

  function automatic dir_row_t mk_row(op_e op, logic [7:0] b, logic [6:0] ix, logic [15:0] ev,
                                      bit typed, kind_e k, logic [31:0] v);
    dir_row_t r;
    r.w.op               = op;
    r.w.data_byte        = b;
    r.w.entry_index      = ix;
    r.w.entry_value      = ev;
    r.typed              = typed;
    r.res.kind           = k;
    r.res.value          = v;
    r.res.has_argument   = 1'b0;
    r.res.argument       = NO_ARG;
    r.res.last           = 1'b1;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 33);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected token kind=%0d value=%h", $time, out_data.kind,
                 out_data.value);
        fails++;
      end else begin
        want = tokens_due.pop_front();
        tokens_checked++;
        if (out_data.kind !== want.kind || out_data.value !== want.value ||
            out_data.has_argument !== want.has_argument ||
            out_data.argument !== want.argument || out_data.last !== want.last) begin
          $display("%0t: expected kind=%0d value=%h has=%b arg=%h last=%b", $time,
                   want.kind, want.value, want.has_argument, want.argument, want.last);
          $display("%0t: actual   kind=%0d value=%h has=%b arg=%h last=%b", $time,
                   out_data.kind, out_data.value, out_data.has_argument,
                   out_data.argument, out_data.last);
          fails++;
        end
      end
    end
  end

  // cycle counter; ends a hung run
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d tokens still due", cycle_cnt, tokens_due.size());
    $display("rtf_token_scanner test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    logic        ph_en  [N_PHASES];
    logic [3:0]  ph_skip[N_PHASES];
    int          i, p, phase_end, mid;
    bit          paused;

    // directed words; typed tokens are plain reads of the scanner rules
    dir_tab = '{
      mk_row(OP_WRITE, 8'h00,     7'h00, 16'hFFFF, 1'b0, K_OPEN,   '0),
      mk_row(OP_WRITE, 8'hFF,     7'h7F, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  CH_LBRACE, 7'h00, 16'h0000, 1'b1, K_OPEN,   '0),
      mk_row(OP_DATA,  CH_RBRACE, 7'h7F, 16'hFFFF, 1'b1, K_CLOSE,  '0),
      mk_row(OP_DATA,  8'h00,     7'h00, 16'h0000, 1'b1, K_CHAR,   32'h00),
      mk_row(OP_DATA,  8'hFF,     7'h00, 16'h0000, 1'b1, K_CHAR,   32'hFF),
      // escaped brace
      mk_row(OP_DATA,  CH_BSLASH, 7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  CH_RBRACE, 7'h00, 16'h0000, 1'b1, K_CHAR,   32'(CH_RBRACE)),
      // bad escape
      mk_row(OP_DATA,  CH_BSLASH, 7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  "*",       7'h00, 16'h0000, 1'b1, K_ERROR,  32'h2A),
      // \fs-2x : letter held one byte, negative argument, then plain char
      mk_row(OP_DATA,  CH_BSLASH, 7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  "f",       7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  "s",       7'h00, 16'h0000, 1'b1, K_LETTER, 32'h66),
      mk_row(OP_DATA,  CH_MINUS,  7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  "2",       7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  "x",       7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      // \u9 then the ending byte is skipped
      mk_row(OP_DATA,  CH_BSLASH, 7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  CH_U,      7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  "9",       7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  CH_SPACE,  7'h00, 16'h0000, 1'b1, K_CHAR,   32'd9),
      // lone minus kills the scanner until end of stream
      mk_row(OP_DATA,  CH_BSLASH, 7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  "b",       7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  CH_MINUS,  7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_DATA,  "q",       7'h00, 16'h0000, 1'b1, K_ERROR,  32'h71),
      mk_row(OP_NONE,  8'hFF,     7'h7F, 16'hFFFF, 1'b0, K_OPEN,   '0),
      mk_row(OP_END,   8'h00,     7'h00, 16'h0000, 1'b1, K_EOS,    '0),
      // dangling backslash flushed at end of stream
      mk_row(OP_DATA,  CH_BSLASH, 7'h00, 16'h0000, 1'b0, K_OPEN,   '0),
      mk_row(OP_END,   8'hFF,     7'h7F, 16'hFFFF, 1'b0, K_OPEN,   '0)
    };

    // register settings per random phase, extremes included
    ph_en   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom_range(1))};
    ph_skip = '{4'd0, 4'd15, 4'd7, 4'd1, 4'd0, 4'($urandom_range(15))};

    tbl_en = 1'b0;
    uskip  = 4'd1;
    clear_scan();

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_ROWS; i++) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);

    for (p = 0; p < N_PHASES; p++) begin
      drain();
      cfg_write(REG_TABLE_ENABLE, 32'(ph_en[p]));
      cfg_write(REG_UNICODE_SKIP, 32'(ph_skip[p]));
      calm      = (p == 1);
      phase_end = words_fed + PHASE_WORDS;
      mid       = words_fed + PHASE_WORDS / 2;
      paused    = 1'b0;
      while (words_fed < phase_end) begin
        // a dead scanner only wakes on end of stream
        if (scan_st == M_DEAD && $urandom_range(3) != 0) send_op(OP_END);
        else feed_fragment();
        if (!paused && words_fed >= mid) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    calm = 1'b0;
    drain();

    $display("scanner saw %0d words and returned %0d tokens over %0d register settings",
             words_fed, tokens_checked, N_PHASES + 1);
    $display("mismatches: %0d, tokens left over: %0d", fails, tokens_due.size());
    if (fails == 0 && tokens_due.size() == 0) begin
      $display("rtf_token_scanner test passed");
    end else begin
      $display("rtf_token_scanner test failed");
    end
    $finish;
  end

endmodule
